// File: hdl/rau_pkg.sv
// Package: shared types, constants and codes of the rational arithmetic unit.
package rau_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAG_W          = 32;
  localparam int WIDE_W         = 64;
  localparam int KIND_W         = 3;
  localparam int SHIFT_W        = $clog2(WIDE_W) + 1;
  localparam int CNT_W          = $clog2(WIDE_W);

  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CMP = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_CMP,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_R
  } phase_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              a_neg;
    logic [MAG_W-1:0]  a_mag;
    logic [MAG_W-1:0]  a_den;
    logic              b_neg;
    logic [MAG_W-1:0]  b_mag;
    logic [MAG_W-1:0]  b_den;
  } op_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctl_t;

endpackage

// File: hdl/rau_ifs.sv
// Interfaces: input and result channels of the rational arithmetic unit.
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic        less;
  logic        same;
  logic        overflow;
  modport source (output valid, res_num, res_den, less, same, overflow, input ready);
  modport sink (input valid, res_num, res_den, less, same, overflow, output ready);
endinterface

// File: hdl/rau_front.sv
// Front end: accepts items and splits raw fields into signs and magnitudes.
module rau_front #(
  parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
  rau_in_if.sink       in_i,
  input  logic         full_i,
  output logic         push_o,
  output rau_pkg::op_t op_o
);

  function automatic logic [VALUE_BITS:0] split(input logic [31:0] raw);
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] m;
    begin
      v = raw[VALUE_BITS-1:0];
      m = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
      split = {v[VALUE_BITS-1], m};
    end
  endfunction

  logic [VALUE_BITS:0] an, ad, bn, bd;

  assign an = split(in_i.a_num);
  assign ad = split(in_i.a_den);
  assign bn = split(in_i.b_num);
  assign bd = split(in_i.b_den);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    op_o.kind  = in_i.kind;
    op_o.a_neg = an[VALUE_BITS] ^ ad[VALUE_BITS];
    op_o.a_mag = rau_pkg::MAG_W'(an[VALUE_BITS-1:0]);
    op_o.a_den = rau_pkg::MAG_W'(ad[VALUE_BITS-1:0]);
    op_o.b_neg = bn[VALUE_BITS] ^ bd[VALUE_BITS];
    op_o.b_mag = rau_pkg::MAG_W'(bn[VALUE_BITS-1:0]);
    op_o.b_den = rau_pkg::MAG_W'(bd[VALUE_BITS-1:0]);
  end

endmodule

// File: hdl/rau_fifo.sv
// Two-entry queue between front end and back end.
module rau_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            pop_i,
  input  rau_pkg::op_t    wdata_i,
  output rau_pkg::op_t    rdata_o,
  output rau_pkg::q_ctl_t ctl_o
);

  rau_pkg::op_t mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign ctl_o.push  = push_i;
  assign ctl_o.pop   = pop_i;
  assign ctl_o.full  = (cnt_q == 2'd2);
  assign ctl_o.empty = (cnt_q == 2'd0);
  assign rdata_o     = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// File: hdl/rau_core.sv
// Back end: reduces operands, computes exact result and comparison, drives results.
module rau_core #(
  parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rau_pkg::q_ctl_t ctl_i,
  input  rau_pkg::op_t    op_i,
  output logic            pop_o,
  rau_out_if.source       out_o
);

  localparam int W  = rau_pkg::WIDE_W;
  localparam int MW = rau_pkg::MAG_W;
  localparam logic [W-1:0] LIM = W'(1) << (VALUE_BITS - 1);

  rau_pkg::state_e st_q, st_d;
  rau_pkg::phase_e ph_q, ph_d;

  logic [rau_pkg::KIND_W-1:0] kind_q;
  logic          an_q, bn_q, au_q, bu_q;
  logic [MW-1:0] am_q, ad_q, bm_q, bd_q;
  logic [W-1:0]  ta_q, tb_q, dd_q, mm_q;
  logic [1:0]    mcnt_q;
  logic          rneg_q, ru_q;
  logic [W-1:0]  rmag_q, rden_q;
  logic          less_q, same_q;
  logic [W-1:0]  sm_q, sd_q, u_q, v_q, g_q, dq_q, rem_q, qm_q;
  logic          sneg_q;
  logic [rau_pkg::SHIFT_W-1:0] k_q;
  logic [rau_pkg::CNT_W-1:0]   dcnt_q;
  logic          dsel_q;
  logic          ov_valid_q;

  logic          arith;
  logic [W-1:0]  src_mag, src_den;
  logic          src_neg;
  logic          commit;
  logic          c_und, c_neg;
  logic [W-1:0]  c_mag, c_den;
  logic [W:0]    trial;
  logic          ge;
  logic [W-1:0]  rem_n, dq_n;
  logic          out_load;
  logic [MW-1:0] mul_a, mul_b;
  logic [W-1:0]  prod;
  logic          bneg;
  logic          fit;

  assign arith = (kind_q <= rau_pkg::KIND_DIV);
  assign bneg  = bn_q ^ (kind_q == rau_pkg::KIND_SUB);
  assign trial = {rem_q, dq_q[W-1]};
  assign ge    = trial >= {1'b0, g_q};
  assign rem_n = ge ? W'(trial - {1'b0, g_q}) : trial[W-1:0];
  assign dq_n  = {dq_q[W-2:0], ge};
  assign prod  = W'(mul_a) * W'(mul_b);
  assign fit   = (rden_q <= LIM - 1) && (rneg_q ? (rmag_q <= LIM) : (rmag_q <= LIM - 1));
  assign out_load = (st_q == rau_pkg::ST_FIN) && (!ov_valid_q || out_o.ready);
  assign pop_o    = (st_q == rau_pkg::ST_IDLE) && !ctl_i.empty;

  always_comb begin
    case (ph_q)
      rau_pkg::PH_A: begin
        src_mag = W'(am_q); src_den = W'(ad_q); src_neg = an_q;
      end
      rau_pkg::PH_B: begin
        src_mag = W'(bm_q); src_den = W'(bd_q); src_neg = bn_q;
      end
      default: begin
        src_mag = rmag_q; src_den = rden_q; src_neg = rneg_q;
      end
    endcase
  end

  always_comb begin
    case (mcnt_q)
      2'd0:    begin mul_a = am_q; mul_b = bd_q; end
      2'd1:    begin mul_a = bm_q; mul_b = ad_q; end
      2'd2:    begin mul_a = ad_q; mul_b = bd_q; end
      default: begin mul_a = am_q; mul_b = bm_q; end
    endcase
  end

  always_comb begin
    st_d   = st_q;
    ph_d   = ph_q;
    commit = 1'b0;
    c_und  = 1'b0;
    c_neg  = 1'b0;
    c_mag  = '0;
    c_den  = W'(1);
    case (st_q)
      rau_pkg::ST_IDLE: begin
        if (!ctl_i.empty) begin
          st_d = rau_pkg::ST_SETUP;
          ph_d = rau_pkg::PH_A;
        end
      end
      rau_pkg::ST_SETUP: begin
        if (src_den == '0) begin
          commit = 1'b1; c_und = 1'b1; c_mag = W'(1); c_den = '0;
        end else if (src_mag == '0) begin
          commit = 1'b1;
        end else begin
          st_d = rau_pkg::ST_GCD;
        end
      end
      rau_pkg::ST_GCD: begin
        if (u_q == v_q) st_d = rau_pkg::ST_DIV;
      end
      rau_pkg::ST_DIV: begin
        if (dsel_q && dcnt_q == '1) begin
          commit = 1'b1; c_neg = sneg_q; c_mag = qm_q; c_den = dq_n;
        end
      end
      rau_pkg::ST_MUL: begin
        if (mcnt_q == 2'd3) st_d = rau_pkg::ST_CMP;
      end
      rau_pkg::ST_CMP: begin
        if (!arith || au_q || bu_q) st_d = rau_pkg::ST_FIN;
        else begin
          st_d = rau_pkg::ST_SETUP;
          ph_d = rau_pkg::PH_R;
        end
      end
      rau_pkg::ST_FIN: begin
        if (out_load) st_d = rau_pkg::ST_IDLE;
      end
      default: st_d = rau_pkg::ST_IDLE;
    endcase
    if (commit) begin
      case (ph_q)
        rau_pkg::PH_A: begin
          st_d = rau_pkg::ST_SETUP; ph_d = rau_pkg::PH_B;
        end
        rau_pkg::PH_B: begin
          st_d = rau_pkg::ST_MUL;
        end
        default: st_d = rau_pkg::ST_FIN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= rau_pkg::ST_IDLE;
      ph_q       <= rau_pkg::PH_A;
      ov_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ph_q <= ph_d;
      if (out_load) ov_valid_q <= 1'b1;
      else if (out_o.ready) ov_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      rau_pkg::ST_IDLE: begin
        kind_q <= op_i.kind;
        an_q <= op_i.a_neg; am_q <= op_i.a_mag; ad_q <= op_i.a_den;
        bn_q <= op_i.b_neg; bm_q <= op_i.b_mag; bd_q <= op_i.b_den;
        au_q <= 1'b0; bu_q <= 1'b0; ru_q <= 1'b0;
        mcnt_q <= 2'd0;
      end
      rau_pkg::ST_SETUP: begin
        sm_q <= src_mag; sd_q <= src_den; sneg_q <= src_neg;
        u_q  <= src_mag; v_q  <= src_den; k_q <= '0;
      end
      rau_pkg::ST_GCD: begin
        if (u_q == v_q) begin
          g_q    <= W'(u_q << k_q);
          dq_q   <= sm_q;
          rem_q  <= '0;
          dcnt_q <= '0;
          dsel_q <= 1'b0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1; v_q <= v_q >> 1; k_q <= k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q > v_q) begin
          u_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
      rau_pkg::ST_DIV: begin
        dcnt_q <= dcnt_q + 1'b1;
        if (dcnt_q == '1 && !dsel_q) begin
          qm_q   <= dq_n;
          dq_q   <= sd_q;
          rem_q  <= '0;
          dsel_q <= 1'b1;
        end else begin
          dq_q  <= dq_n;
          rem_q <= rem_n;
        end
      end
      rau_pkg::ST_MUL: begin
        mcnt_q <= mcnt_q + 2'd1;
        case (mcnt_q)
          2'd0:    ta_q <= prod;
          2'd1:    tb_q <= prod;
          2'd2:    dd_q <= prod;
          default: mm_q <= prod;
        endcase
      end
      rau_pkg::ST_CMP: begin
        if (au_q || bu_q) begin
          less_q <= 1'b0;
          same_q <= au_q && bu_q;
          ru_q   <= 1'b1;
        end else begin
          same_q <= (an_q == bn_q) && (am_q == bm_q) && (ad_q == bd_q);
          if (an_q != bn_q) less_q <= an_q;
          else if (an_q) less_q <= ta_q > tb_q;
          else less_q <= ta_q < tb_q;
        end
        case (kind_q)
          rau_pkg::KIND_MUL: begin
            rneg_q <= an_q ^ bn_q; rmag_q <= mm_q; rden_q <= dd_q;
          end
          rau_pkg::KIND_DIV: begin
            rneg_q <= an_q ^ bn_q; rmag_q <= ta_q; rden_q <= tb_q;
          end
          default: begin
            rden_q <= dd_q;
            if (an_q == bneg) begin
              rneg_q <= an_q; rmag_q <= ta_q + tb_q;
            end else if (ta_q >= tb_q) begin
              rneg_q <= an_q; rmag_q <= ta_q - tb_q;
            end else begin
              rneg_q <= bneg; rmag_q <= tb_q - ta_q;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
    if (commit) begin
      case (ph_q)
        rau_pkg::PH_A: begin
          au_q <= c_und; an_q <= c_neg; am_q <= MW'(c_mag); ad_q <= MW'(c_den);
        end
        rau_pkg::PH_B: begin
          bu_q <= c_und; bn_q <= c_neg; bm_q <= MW'(c_mag); bd_q <= MW'(c_den);
        end
        default: begin
          ru_q <= c_und; rneg_q <= c_neg; rmag_q <= c_mag; rden_q <= c_den;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.less <= less_q;
      out_o.same <= same_q;
      if (!arith) begin
        out_o.res_num <= '0; out_o.res_den <= '0; out_o.overflow <= 1'b0;
      end else if (ru_q) begin
        out_o.res_num <= 32'd1; out_o.res_den <= '0; out_o.overflow <= 1'b0;
      end else if (fit) begin
        out_o.res_num  <= rneg_q ? (32'd0 - rmag_q[31:0]) : rmag_q[31:0];
        out_o.res_den  <= rden_q[30:0];
        out_o.overflow <= 1'b0;
      end else begin
        out_o.res_num <= '0; out_o.res_den <= '0; out_o.overflow <= 1'b1;
      end
    end
  end

  assign out_o.valid = ov_valid_q;

endmodule

// File: hdl/rational_arithmetic_unit.sv
// Top level: exact rational arithmetic on gcd-reduced fractions.
// Each operand, and each arithmetic result, is reduced by a binary gcd
// (one 64-bit step a cycle) and two restoring divisions if nonzero and defined.
// Throughput: one item at a time in the back end; a two-entry queue lets the
// front end keep accepting items, until it is full, while the back end works.
// Reset: asynchronous, active low; clears the control state and the queue.
module rational_arithmetic_unit #(
  parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);

  rau_pkg::op_t    f_op, q_op;
  rau_pkg::q_ctl_t q_ctl;
  logic            push, pop;

  rau_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .in_i   (in_i),
    .full_i (q_ctl.full),
    .push_o (push),
    .op_o   (f_op)
  );

  rau_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .wdata_i (f_op),
    .rdata_o (q_op),
    .ctl_o   (q_ctl)
  );

  rau_core #(.VALUE_BITS(VALUE_BITS)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (q_ctl),
    .op_i   (q_op),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ctl.full |-> !q_ctl.push) else $error("queue overrun");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ctl.empty |-> !q_ctl.pop) else $error("queue underrun");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflow) |-> (out_o.res_num == '0 && out_o.res_den == '0))
    else $error("overflow result not cleared");

  a_less_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.less && out_o.same)) else $error("less and same both set");

endmodule

// File: dv/rau_checker.sv
// Checker: watches both channels of the rational unit, predicts results and compares them.
module rau_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.sink   out_o,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        less;
    logic        same;
    logic        overflow;
  } rau_result_t;

  typedef struct {
    bit          undef;
    bit          neg;
    logic [63:0] mag;
    logic [63:0] den;
  } fraction_t;

  rau_result_t expected_q[$];
  int          fails;

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t reduce(bit neg, logic [63:0] mag, logic [63:0] den);
    fraction_t f;
    logic [63:0] g;
    f = '{0, 0, 64'd0, 64'd1};
    if (den == 0) begin
      f = '{1, 0, 64'd1, 64'd0};
    end else if (mag != 0) begin
      g = gcd64(mag, den);
      f = '{0, neg, mag / g, den / g};
    end
    return f;
  endfunction

  function automatic fraction_t load(logic [31:0] n, logic [31:0] d);
    logic [63:0] nm, dm;
    nm = n[31] ? 64'(-n) : 64'(n);
    dm = d[31] ? 64'(-d) : 64'(d);
    if (n[31]) nm = 64'h1_0000_0000 - {32'd0, n};
    if (d[31]) dm = 64'h1_0000_0000 - {32'd0, d};
    return reduce(n[31] ^ d[31], nm, dm);
  endfunction

  function automatic rau_result_t compute(logic [2:0] kind, logic [31:0] an, logic [31:0] ad,
                                          logic [31:0] bn, logic [31:0] bd);
    rau_result_t res;
    fraction_t   a, b, r;
    logic [63:0] ta, tb, lim;
    bit          bneg;
    longint      x, y;
    a = load(an, ad);
    b = load(bn, bd);
    res = '{32'd0, 31'd0, 1'b0, 1'b0, 1'b0};
    lim = 64'h8000_0000;
    if (a.undef || b.undef) begin
      res.same = a.undef && b.undef;
    end else begin
      x = a.mag * b.den;
      y = b.mag * a.den;
      if (a.neg) x = -x;
      if (b.neg) y = -y;
      res.less = x < y;
      res.same = a.neg == b.neg && a.mag == b.mag && a.den == b.den;
    end
    if (kind <= rau_pkg::KIND_DIV) begin
      if (a.undef || b.undef) begin
        r = reduce(0, 64'd1, 64'd0);
      end else if (kind == rau_pkg::KIND_ADD || kind == rau_pkg::KIND_SUB) begin
        ta = a.mag * b.den;
        tb = b.mag * a.den;
        bneg = b.neg ^ (kind == rau_pkg::KIND_SUB);
        if (a.neg == bneg) r = reduce(a.neg, ta + tb, a.den * b.den);
        else if (ta >= tb) r = reduce(a.neg, ta - tb, a.den * b.den);
        else r = reduce(bneg, tb - ta, a.den * b.den);
      end else if (kind == rau_pkg::KIND_MUL) begin
        r = reduce(a.neg ^ b.neg, a.mag * b.mag, a.den * b.den);
      end else begin
        r = reduce(a.neg ^ b.neg, a.mag * b.den, a.den * b.mag);
      end
      if (r.undef) begin
        res.num = 32'd1;
      end else if (r.den > lim - 1 || (r.neg ? r.mag > lim : r.mag > lim - 1)) begin
        res.overflow = 1'b1;
      end else begin
        res.num = r.neg ? 32'(-r.mag) : r.mag[31:0];
        res.den = r.den[30:0];
      end
    end
    return res;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rau_result_t e;
    if (!rst_ni) begin
      fails = 0;
    end else begin
      if (in_i.valid && in_i.ready)
        expected_q.insert(expected_q.size(),
                          compute(in_i.kind, in_i.a_num, in_i.a_den, in_i.b_num, in_i.b_den));
      if (out_o.valid && out_o.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_o.res_num !== e.num) report("res_num", out_o.res_num, e.num);
          if (out_o.res_den !== e.den) report("res_den", out_o.res_den, e.den);
          if (out_o.less !== e.less) report("less", out_o.less, e.less);
          if (out_o.same !== e.same) report("same", out_o.same, e.same);
          if (out_o.overflow !== e.overflow) report("overflow", out_o.overflow, e.overflow);
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();
endmodule

// File: dv/tb_rational_arithmetic_unit.sv
// Testbench top: drives the rational unit with directed and random items and gives the verdict.
module tb_rational_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1730;
  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  longint cycles;
  bit   hold_off;

  rau_in_if  in_ch ();
  rau_out_if out_ch ();

  rational_arithmetic_unit DUT (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  rau_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic [31:0] pick_value();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'(int'($urandom_range(0, 6)) - 3);
      4, 5: return 32'($urandom_range(0, 200)) * ($urandom_range(0, 1) ? 32'd1 : -32'd1);
      6: return 32'($urandom_range(1, 1000)) * 32'($urandom_range(1, 1000))
                * ($urandom_range(0, 1) ? 32'd1 : -32'd1);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [2:0] kind, logic [31:0] an, logic [31:0] ad,
                      logic [31:0] bn, logic [31:0] bd);
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.a_num <= an;
    in_ch.a_den <= ad;
    in_ch.b_num <= bn;
    in_ch.b_den <= bd;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic idle_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      out_ch.ready <= (g == 0) || ($urandom_range(0, 3) == 0);
      @(posedge clk_i);
      if (g > 0 && g < 5) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [2:0] kind;
    cycles = 0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = rau_pkg::KIND_ADD;
    in_ch.a_num = '0;
    in_ch.a_den = '0;
    in_ch.b_num = '0;
    in_ch.b_den = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(rau_pkg::KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send(rau_pkg::KIND_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send(rau_pkg::KIND_MUL, -32'd4, 32'd6, 32'd3, -32'd8);
    send(rau_pkg::KIND_DIV, 32'd5, 32'd7, 32'd0, 32'd9);
    send(rau_pkg::KIND_CMP, 32'd1, 32'd3, 32'd2, 32'd6);
    send(rau_pkg::KIND_ADD, 32'd3, 32'd0, 32'd1, 32'd2);
    send(rau_pkg::KIND_CMP, 32'd3, 32'd0, -32'd1, 32'd0);
    send(rau_pkg::KIND_MUL, 32'd0, -32'd5, 32'd7, 32'd3);
    send(rau_pkg::KIND_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
    send(rau_pkg::KIND_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send(rau_pkg::KIND_MUL, 32'h8000_0000, 32'd1, -32'd1, 32'd1);
    send(rau_pkg::KIND_DIV, 32'd1, 32'h8000_0000, -32'd1, 32'd1);
    send(rau_pkg::KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send(rau_pkg::KIND_ADD, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
    send(rau_pkg::KIND_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send(3'd5, 32'd1, 32'd2, 32'd3, 32'd4);
    send(3'd7, -32'd1, 32'd2, 32'd1, -32'd2);
    send(rau_pkg::KIND_CMP, -32'd1, 32'd2, 32'd1, 32'd2);
    send(rau_pkg::KIND_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    hold_off = 1'b1;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      send(kind, pick_value(), pick_value(), pick_value(), pick_value());
      idle_gap();
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
